FILE: rtl/core/sse_pkg.sv
package sse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;
    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     end_of_set;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_result;
        logic                     overflow_seen;
    } t_out_beat;

    // A classified input beat: store says the value fits in the buffer.
    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     store;
        logic                     last;
    } t_cmd;

endpackage

FILE: rtl/core/sse_front.sv
module sse_front #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sse_pkg::t_in_beat i_data,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output sse_pkg::t_cmd     o_cmd
);
    import sse_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    t_cmd          r_queue [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [LW-1:0] r_level;
    logic          push;
    logic          pop;
    t_cmd          cmd_in;

    assign o_ready     = (r_level != LW'(QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_level != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_queue[r_rd_ptr];

    // The front keeps its own count of the set so that each beat is tagged
    // as stored or dropped before it reaches the queue.
    always_comb begin
        cmd_in.sample_value = i_data.sample_value;
        cmd_in.store        = (r_fill < CW'(MAX_ITEMS));
        cmd_in.last         = i_data.end_of_set;
        n_fill              = r_fill;
        if (push) begin
            if (i_data.end_of_set) begin
                n_fill = '0;
            end else if (cmd_in.store) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: rtl/core/sse_back.sv
module sse_back #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  sse_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output sse_pkg::t_out_beat o_data
);
    import sse_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GAP   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_HOLD  = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_PUT   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EWAIT = 4'd7;
    localparam logic [3:0] S_EHOLD = 4'd8;

    logic signed [DATA_W-1:0] r_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_rdata;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;

    logic [3:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_ovf, n_ovf;
    logic [CW-1:0]            r_gap, n_gap;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_held, n_held;
    logic                     r_out_valid, n_out_valid;
    t_out_beat                r_out, n_out;

    logic [CW-1:0]            idx_next;
    logic [CW-1:0]            gap_half;
    logic [CW-1:0]            pos_down;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    assign idx_next = r_idx + 1'b1;
    assign gap_half = r_gap >> 1;
    assign pos_down = r_pos - r_gap;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_gap       = r_gap;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_wdata   = r_held;
        mem_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.store) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = i_cmd.sample_value;
                        n_count   = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_cmd.last) begin
                        n_state = S_GAP;
                    end
                end
            end
            S_GAP: begin
                n_gap = r_count >> 1;
                n_idx = r_count >> 1;
                if ((r_count >> 1) == '0) begin
                    n_idx   = '0;
                    n_state = S_ERD;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_HOLD;
            end
            S_HOLD: begin
                n_held    = r_rdata;
                n_pos     = r_idx;
                mem_raddr = AW'(r_idx - r_gap);
                n_state   = S_CMP;
            end
            S_CMP, S_PUT: begin
                if (r_state == S_CMP && r_rdata > r_held) begin
                    // Shift the larger value up by one gap and keep walking.
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata;
                    n_pos     = pos_down;
                    mem_raddr = AW'(pos_down - r_gap);
                    n_state   = (pos_down >= r_gap) ? S_CMP : S_PUT;
                end else begin
                    // Closing one insertion step: move to the next index, or once the index runs off
                    // the end of the set, to the next gap, or to output if no gap is left.
                    mem_we = 1'b1;
                    if (idx_next < r_count) begin
                        n_idx     = idx_next;
                        mem_raddr = idx_next[AW-1:0];
                        n_state   = S_HOLD;
                    end else begin
                        n_gap = gap_half;
                        if (gap_half == '0) begin
                            n_idx   = '0;
                            n_state = S_ERD;
                        end else begin
                            n_idx   = gap_half;
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_ERD: begin
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_EWAIT;
            end
            S_EWAIT: begin
                n_out.sorted_value  = r_rdata;
                n_out.final_result  = (idx_next == r_count);
                n_out.overflow_seen = r_ovf;
                n_out_valid         = 1'b1;
                n_state             = S_EHOLD;
            end
            S_EHOLD: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.final_result) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = idx_next;
                        mem_raddr = idx_next[AW-1:0];
                        n_state   = S_EWAIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap  <= n_gap;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_held <= n_held;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

FILE: rtl/core/shell_sort_engine.sv
// Input beats are taken at one per cycle into a four-deep command queue while
// the queue has room; the sorter stores one queued beat per cycle while it
// collects a set. After its last beat, each gap starts with a load state, and
// each gapped insertion step reads its value in a hold state, then shifts larger
// entries up by the gap in compare states. Results are held until taken, and no
// new beat leaves the queue until the last result of the set has been taken.
// Synchronous active-low reset empties the queue and clears count and overflow.
module shell_sort_engine #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sse_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sse_pkg::t_out_beat o_data
);
    import sse_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    sse_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    sse_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

FILE: dv/shell_sort_engine_test.sv
`timescale 1ns / 1ps

module shell_sort_engine_test;
    import sse_pkg::*;

    localparam int CAPACITY   = MAX_ITEMS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_LEN   = 500;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    shell_sort_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus waiting to go out, and sorted results waiting to come back.
    t_in_beat  sample_queue[$];
    t_out_beat sorted_queue[$];

    // Shadow of the set being collected.
    logic signed [DATA_W-1:0] held_vals[CAPACITY];
    int unsigned held_cnt;
    bit          dropped;

    int fail_count;
    int mismatch_count;
    int results_checked;
    int sets_closed;
    int overflow_sets;
    int largest_set;
    int items_planned;

    // Takes one accepted beat into the shadow set; on the closing beat, sorts
    // the held values with halving gaps and queues the sorted results.
    task automatic collect_and_sort(input t_in_beat beat);
        logic signed [DATA_W-1:0] carry;
        t_out_beat                res;
        int                       gap;
        int                       pos;
        int                       n;
        if (held_cnt < CAPACITY) begin
            held_vals[held_cnt] = beat.sample_value;
            held_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (beat.end_of_set) begin
            n = held_cnt;
            for (gap = n / 2; gap > 0; gap = gap / 2) begin
                for (int i = gap; i < n; i++) begin
                    carry = held_vals[i];
                    pos   = i;
                    while (pos >= gap && held_vals[pos-gap] > carry) begin
                        held_vals[pos] = held_vals[pos-gap];
                        pos -= gap;
                    end
                    held_vals[pos] = carry;
                end
            end
            for (int k = 0; k < n; k++) begin
                res.sorted_value  = held_vals[k];
                res.final_result  = (k == n - 1);
                res.overflow_seen = dropped;
                sorted_queue.push_back(res);
            end
            sets_closed++;
            if (dropped) overflow_sets++;
            if (n > largest_set) largest_set = n;
            held_cnt = 0;
            dropped  = 1'b0;
        end
    endtask

    task automatic add_sample(input logic signed [DATA_W-1:0] value, input bit last);
        t_in_beat beat;
        beat.sample_value = value;
        beat.end_of_set   = last;
        sample_queue.push_back(beat);
        items_planned++;
    endtask

    // Values lean toward duplicates and the extremes now and then.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 32'sh0000_0000;
                    default: v = 32'shffff_ffff;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 10)) - 5;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_random_set(input int size);
        for (int k = 0; k < size; k++) add_sample(pick_value(), k == size - 1);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) collect_and_sort(i_data);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    i_data  <= sample_queue.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between stall patterns, with one long hold-off so
    // the input side backs up.
    t_rx_mode rx_mode;
    int       rx_left;
    int       rx_cycle;
    int       hold_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rx_mode   = RX_FREE;
            rx_left   = 0;
            rx_cycle  = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    rx_left = $urandom_range(20, 150);
                end
                rx_left--;
                case (rx_mode)
                    RX_FREE:   i_ready <= 1'b1;
                    RX_RANDOM: i_ready <= ($urandom_range(0, 1) == 1);
                    default:   i_ready <= (rx_cycle % 4 == 0);
                endcase
            end
        end
    end

    // Result checker.
    t_out_beat want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_queue.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %0d last %0b overflow %0b",
                             o_data.sorted_value, o_data.final_result, o_data.overflow_seen);
            end else begin
                want = sorted_queue.pop_front();
                if (o_data.sorted_value !== want.sorted_value
                        || o_data.final_result !== want.final_result
                        || o_data.overflow_seen !== want.overflow_seen) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                                 results_checked, want.sorted_value, want.final_result,
                                 want.overflow_seen, o_data.sorted_value,
                                 o_data.final_result, o_data.overflow_seen);
                end
            end
            results_checked++;
        end
    end

    // Watchdog on cycles without any beat moving.
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int size;
        int big_sets;

        held_cnt = 0;
        dropped  = 1'b0;

        // Single-value sets at both extremes.
        add_sample(32'sh8000_0000, 1'b1);
        add_sample(32'sh7fff_ffff, 1'b1);
        // Extremes, zero and minus one mixed together.
        add_sample(32'sh0000_0000, 1'b0);
        add_sample(32'shffff_ffff, 1'b0);
        add_sample(32'sh7fff_ffff, 1'b0);
        add_sample(32'sh8000_0000, 1'b0);
        add_sample(32'sh0000_0001, 1'b1);
        // Repeated values.
        add_sample(7, 1'b0);
        add_sample(-7, 1'b0);
        add_sample(7, 1'b0);
        add_sample(7, 1'b1);
        // Strictly descending input.
        for (int k = 5; k >= 0; k--) add_sample(k * 10, k == 0);
        add_sample(3, 1'b0);
        add_sample(-3, 1'b1);

        // An exactly full set, then one that overflows so even the closing
        // value is dropped.
        add_random_set(CAPACITY);
        add_random_set(CAPACITY + 1 + $urandom_range(0, 3));
        big_sets = 2;
        while (items_planned < 410) begin
            case ($urandom_range(0, 19))
                0: size = (big_sets < 4) ? CAPACITY + $urandom_range(0, 2) : 2;
                1, 2: size = $urandom_range(13, 40);
                3: size = 2;
                default: size = $urandom_range(1, 12);
            endcase
            if (size >= CAPACITY) big_sets++;
            add_random_set(size);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (sorted_queue.size() != 0) begin
            fail_count += sorted_queue.size();
            $display("%0d expected results never arrived", sorted_queue.size());
        end
        $display("Sorted %0d sets from %0d values (%0d with dropped values, largest %0d held).",
                 sets_closed, items_planned, overflow_sets, largest_set);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
